// ----- design/xte_pkg.sv -----
// Shared types and constants for the XML text escaper.
// No dependencies; imported by every module of the block.
package xte_pkg;

  localparam int unsigned XTE_JOB_DEPTH = 2;

  typedef enum logic [2:0] {
    KIND_PASS,
    KIND_AMP,
    KIND_LT,
    KIND_GT,
    KIND_QUOT,
    KIND_REF
  } xte_kind_e;

  typedef struct packed {
    xte_kind_e   kind;
    logic [7:0]  lit;
    logic [1:0]  tens;
    logic [3:0]  ones;
    logic [2:0]  len;
  } xte_job_t;

  localparam logic [7:0] CH_AMP   = 8'h26;
  localparam logic [7:0] CH_LT    = 8'h3c;
  localparam logic [7:0] CH_GT    = 8'h3e;
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_SEMI  = 8'h3b;
  localparam logic [7:0] CH_ZERO  = 8'h30;

endpackage

// ----- design/xte_front.sv -----
// Front end: classifies each accepted byte into an escape job.
// Depends on xte_pkg.
module xte_front import xte_pkg::*; (
  input  logic       push,
  input  logic       full,
  input  logic [7:0] char_byte_i,
  input  logic       in_attribute_i,
  input  logic       is_first_i,
  input  logic       is_last_i,
  output logic       wr_o,
  output xte_job_t   job_o
);

  logic [1:0] tens;
  logic [5:0] ones_wide;
  logic       is_ref;

  assign wr_o = push && !full;

  always_comb begin
    if (char_byte_i >= 8'd30) begin
      tens = 2'd3;
    end else if (char_byte_i >= 8'd20) begin
      tens = 2'd2;
    end else if (char_byte_i >= 8'd10) begin
      tens = 2'd1;
    end else begin
      tens = 2'd0;
    end
    ones_wide = char_byte_i[5:0] - 6'(tens) * 6'd10;
    is_ref = (char_byte_i < CH_SPACE) ||
             (char_byte_i == CH_SPACE && !in_attribute_i && (is_first_i || is_last_i));

    job_o.lit  = char_byte_i;
    job_o.tens = tens;
    job_o.ones = ones_wide[3:0];
    if (char_byte_i == CH_AMP) begin
      job_o.kind = KIND_AMP;
      job_o.len  = 3'd5;
    end else if (char_byte_i == CH_LT) begin
      job_o.kind = KIND_LT;
      job_o.len  = 3'd4;
    end else if (char_byte_i == CH_GT) begin
      job_o.kind = KIND_GT;
      job_o.len  = 3'd4;
    end else if (char_byte_i == CH_QUOTE && in_attribute_i) begin
      job_o.kind = KIND_QUOT;
      job_o.len  = 3'd6;
    end else if (is_ref) begin
      job_o.kind = KIND_REF;
      job_o.len  = (tens != 2'd0) ? 3'd5 : 3'd4;
    end else begin
      job_o.kind = KIND_PASS;
      job_o.len  = 3'd1;
    end
  end

endmodule

// ----- design/xte_job_fifo.sv -----
// Short job queue between the classifier and the expander.
// Depends on xte_pkg.
module xte_job_fifo import xte_pkg::*; #(
  parameter int unsigned Depth = XTE_JOB_DEPTH
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     wr_i,
  input  xte_job_t wr_job_i,
  output logic     full_o,
  input  logic     rd_i,
  output xte_job_t rd_job_o,
  output logic     empty_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  xte_job_t          mem_q [Depth];
  logic [PtrW-1:0]   wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]   rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]   cnt_q, cnt_d;

  assign full_o   = (cnt_q == CntW'(Depth));
  assign empty_o  = (cnt_q == '0);
  assign rd_job_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (wr_i) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (rd_i) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (wr_i && !rd_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (rd_i && !wr_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_i) begin
      mem_q[wr_ptr_q] <= wr_job_i;
    end
  end

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(Depth)) else $error("job queue count overflow");
  a_no_wr_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_i |-> !full_o) else $error("job written while queue full");
  a_no_rd_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_i |-> !empty_o) else $error("job read while queue empty");

endmodule

// ----- design/xte_back.sv -----
// Back end: expands the head job, a byte per cycle unless stalled.
// Depends on xte_pkg.
module xte_back import xte_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  xte_job_t   job_i,
  input  logic       job_empty_i,
  output logic       job_rd_o,
  output logic       empty,
  input  logic       pop,
  output logic [7:0] out_byte_o,
  output logic       run_end_o
);

  function automatic logic [7:0] char_at(xte_job_t job, logic [2:0] idx);
    logic [7:0] c;
    c = job.lit;
    case (job.kind)
      KIND_AMP: begin
        case (idx)
          3'd0:    c = CH_AMP;
          3'd1:    c = "a";
          3'd2:    c = "m";
          3'd3:    c = "p";
          default: c = CH_SEMI;
        endcase
      end
      KIND_LT, KIND_GT: begin
        case (idx)
          3'd0:    c = CH_AMP;
          3'd1:    c = (job.kind == KIND_LT) ? "l" : "g";
          3'd2:    c = "t";
          default: c = CH_SEMI;
        endcase
      end
      KIND_QUOT: begin
        case (idx)
          3'd0:    c = CH_AMP;
          3'd1:    c = "q";
          3'd2:    c = "u";
          3'd3:    c = "o";
          3'd4:    c = "t";
          default: c = CH_SEMI;
        endcase
      end
      KIND_REF: begin
        case (idx)
          3'd0:    c = CH_AMP;
          3'd1:    c = CH_HASH;
          3'd2:    c = (job.tens != 2'd0) ? CH_ZERO + 8'(job.tens) : CH_ZERO + 8'(job.ones);
          3'd3:    c = (job.tens != 2'd0) ? CH_ZERO + 8'(job.ones) : CH_SEMI;
          default: c = CH_SEMI;
        endcase
      end
      default: c = job.lit;
    endcase
    return c;
  endfunction

  logic       out_valid_q, out_valid_d;
  logic [7:0] out_byte_q, out_byte_d;
  logic       run_end_q, run_end_d;
  logic [2:0] idx_q, idx_d;
  logic       step;
  logic       last;
  logic       take;

  assign take     = pop && out_valid_q;
  assign step     = !job_empty_i && (!out_valid_q || take);
  assign last     = (idx_q == job_i.len - 3'd1);
  assign job_rd_o = step && last;

  assign empty      = !out_valid_q;
  assign out_byte_o = out_byte_q;
  assign run_end_o  = run_end_q;

  always_comb begin
    out_valid_d = out_valid_q;
    out_byte_d  = out_byte_q;
    run_end_d   = run_end_q;
    idx_d       = idx_q;
    if (take) begin
      out_valid_d = 1'b0;
    end
    if (step) begin
      out_valid_d = 1'b1;
      out_byte_d  = char_at(job_i, idx_q);
      run_end_d   = last;
      idx_d       = last ? 3'd0 : idx_q + 3'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      idx_q       <= 3'd0;
    end else begin
      out_valid_q <= out_valid_d;
      idx_q       <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_byte_q <= out_byte_d;
    run_end_q  <= run_end_d;
  end

  a_mid_run_job: assert property (@(posedge clk_i) disable iff (!rst_ni)
    idx_q != 3'd0 |-> !job_empty_i) else $error("job left queue mid-run");
  a_idx_in_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !job_empty_i |-> idx_q < job_i.len) else $error("byte index beyond run length");
  a_rd_on_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    job_rd_o |=> (out_valid_q && run_end_q)) else $error("job retired without run end");

endmodule

// ----- design/xml_text_escaper_top.sv -----
// Top level of the XML text escaper: classifier, job queue and expander.
// Depends on xte_pkg, xte_front, xte_job_fifo and xte_back.
//
// Each accepted byte yields a run of one to six escaped bytes, the last
// marked by run_end_o. Plain bytes flow at one per cycle while the output is
// popped without stalling; an escaped byte holds the expander for its whole
// run (four to six bytes), as the expander emits one output byte per cycle.
// Bytes are classified on entry and wait in a JobDepth-entry job queue, so
// input is taken, up to a full queue, while a run is emitted or a result
// waits to be popped. Results pass the job queue, then the output register.
module xml_text_escaper_top import xte_pkg::*; #(
  parameter int unsigned JobDepth = XTE_JOB_DEPTH
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push,
  output logic       full,
  input  logic [7:0] char_byte_i,
  input  logic       in_attribute_i,
  input  logic       is_first_i,
  input  logic       is_last_i,
  output logic       empty,
  input  logic       pop,
  output logic [7:0] out_byte_o,
  output logic       run_end_o
);

  logic     wr;
  xte_job_t wr_job;
  xte_job_t rd_job;
  logic     job_empty;
  logic     job_rd;

  xte_front u_front (
    .push           (push),
    .full           (full),
    .char_byte_i    (char_byte_i),
    .in_attribute_i (in_attribute_i),
    .is_first_i     (is_first_i),
    .is_last_i      (is_last_i),
    .wr_o           (wr),
    .job_o          (wr_job)
  );

  xte_job_fifo #(
    .Depth (JobDepth)
  ) u_job_fifo (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .wr_i     (wr),
    .wr_job_i (wr_job),
    .full_o   (full),
    .rd_i     (job_rd),
    .rd_job_o (rd_job),
    .empty_o  (job_empty)
  );

  xte_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_i       (rd_job),
    .job_empty_i (job_empty),
    .job_rd_o    (job_rd),
    .empty       (empty),
    .pop         (pop),
    .out_byte_o  (out_byte_o),
    .run_end_o   (run_end_o)
  );

endmodule

// ----- bench/tb_xml_text_escaper_top.sv -----
// Testbench for xml_text_escaper_top: drives bytes with string flags, predicts the
// escaped runs and checks every popped byte and its run_end mark.
// Depends on xte_pkg and the escaper RTL only.
module tb_xml_text_escaper_top;
  import xte_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int IDLE_LIMIT = 2000;
  localparam int RANDOM_ITEMS = 136;
  localparam int DIR_ROWS = 22;

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } out_beat_t;

  typedef struct packed {
    logic [7:0]  ch;
    logic        attr;
    logic        first;
    logic        last;
    logic [47:0] lit;
  } char_row_t;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       push = 1'b0;
  logic       full;
  logic [7:0] char_byte_i = 8'h00;
  logic       in_attribute_i = 1'b0;
  logic       is_first_i = 1'b0;
  logic       is_last_i = 1'b0;
  logic       empty;
  logic       pop = 1'b0;
  logic [7:0] out_byte_o;
  logic       run_end_o;

  logic [47:0]  typed_lit = 48'h0;
  logic         calm = 1'b0;
  out_beat_t    escaped_q [$];
  out_beat_t    want;
  char_row_t    dir_rows [DIR_ROWS];
  int unsigned  pop_wait = 0;
  int           mismatches = 0;
  int           idle_cycles = 0;

  xml_text_escaper_top dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push          (push),
    .full          (full),
    .char_byte_i   (char_byte_i),
    .in_attribute_i(in_attribute_i),
    .is_first_i    (is_first_i),
    .is_last_i     (is_last_i),
    .empty         (empty),
    .pop           (pop),
    .out_byte_o    (out_byte_o),
    .run_end_o     (run_end_o)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(99);
    if (calm) return 0;
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Escaped form of one byte, right-justified, leading zero bytes unused.
  function automatic logic [47:0] escape_text(input logic [7:0] c, input logic attr,
                                              input logic first, input logic last);
    if (c == CH_AMP) return "&amp;";
    if (c == CH_LT) return "&lt;";
    if (c == CH_GT) return "&gt;";
    if (c == CH_QUOTE && attr) return "&quot;";
    if (c < CH_SPACE || (c == CH_SPACE && !attr && (first || last))) begin
      if (c >= 8'd10)
        return {8'h00, CH_AMP, CH_HASH, 8'(CH_ZERO + c / 8'd10), 8'(CH_ZERO + c % 8'd10),
                CH_SEMI};
      return {16'h0000, CH_AMP, CH_HASH, 8'(CH_ZERO + c), CH_SEMI};
    end
    return {40'h0, c};
  endfunction

  function automatic void queue_text(input logic [47:0] txt);
    int n;
    n = 6;
    while (n > 0 && txt[n * 8 - 1 -: 8] == 8'h00) n--;
    for (int k = n - 1; k >= 0; k--) escaped_q.push_back('{txt[k * 8 +: 8], k == 0});
  endfunction

  function automatic logic [7:0] pick_char();
    case ($urandom_range(9))
      0: return CH_AMP;
      1: return $urandom_range(1) ? CH_LT : CH_GT;
      2: return CH_QUOTE;
      3, 4: return CH_SPACE;
      5: return 8'($urandom_range(8'h1f));
      6: return 8'($urandom_range(8'h80, 8'hff));
      default: return 8'($urandom_range(8'h21, 8'h7e));
    endcase
  endfunction

  task automatic send_char(input logic [7:0] c, input logic attr, input logic first,
                           input logic last, input logic [47:0] lit);
    int unsigned gap;
    gap = pick_gap();
    if (gap != 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    push <= 1'b1;
    char_byte_i <= c;
    in_attribute_i <= attr;
    is_first_i <= first;
    is_last_i <= last;
    typed_lit <= lit;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
  endtask

  task automatic drain();
    push <= 1'b0;
    @(posedge clk_i);
    while (escaped_q.size() != 0) @(posedge clk_i);
  endtask

  // Predict on every input transaction, check on every output transaction.
  always @(posedge clk_i) begin
    if (rst_ni && push && !full) begin
      if (typed_lit != 48'h0) queue_text(typed_lit);
      else queue_text(escape_text(char_byte_i, in_attribute_i, is_first_i, is_last_i));
    end
    if (rst_ni && pop && !empty) begin
      if (escaped_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected output: byte %h run_end %b", out_byte_o, run_end_o);
      end else begin
        want = escaped_q.pop_front();
        if (out_byte_o !== want.ch || run_end_o !== want.last) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected byte %h run_end %b, got byte %h run_end %b",
                     want.ch, want.last, out_byte_o, run_end_o);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) pop_wait = pick_gap();
      else if (pop_wait != 0) pop_wait = pop_wait - 1;
      pop <= (pop_wait == 0);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((push && !full) || (pop && !empty)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  initial begin : stimulus
    int sent;
    int len;
    logic attr;

    dir_rows = '{
      '{8'h00, 1'b0, 1'b1, 1'b0, "&#0;"},
      '{8'h1f, 1'b0, 1'b0, 1'b0, "&#31;"},
      '{8'h09, 1'b1, 1'b0, 1'b0, "&#9;"},
      '{8'h0a, 1'b0, 1'b0, 1'b0, "&#10;"},
      '{8'h0d, 1'b1, 1'b0, 1'b1, "&#13;"},
      '{CH_AMP, 1'b0, 1'b0, 1'b0, "&amp;"},
      '{CH_LT, 1'b1, 1'b0, 1'b0, "&lt;"},
      '{CH_GT, 1'b0, 1'b1, 1'b1, "&gt;"},
      '{CH_QUOTE, 1'b1, 1'b0, 1'b0, "&quot;"},
      '{CH_QUOTE, 1'b0, 1'b0, 1'b0, 48'h0},
      '{CH_SPACE, 1'b0, 1'b1, 1'b1, "&#32;"},
      '{CH_SPACE, 1'b0, 1'b1, 1'b0, 48'h0},
      '{CH_SPACE, 1'b0, 1'b0, 1'b1, 48'h0},
      '{CH_SPACE, 1'b0, 1'b0, 1'b0, 48'h0},
      '{CH_SPACE, 1'b1, 1'b1, 1'b1, 48'h0},
      '{8'hff, 1'b1, 1'b1, 1'b1, 48'h0000_0000_00ff},
      '{8'h80, 1'b1, 1'b0, 1'b0, 48'h0},
      '{8'h7f, 1'b0, 1'b0, 1'b0, 48'h0},
      '{8'h21, 1'b0, 1'b1, 1'b0, 48'h0},
      '{8'h41, 1'b1, 1'b0, 1'b1, 48'h0},
      '{8'h19, 1'b0, 1'b1, 1'b1, 48'h0},
      '{CH_SEMI, 1'b1, 1'b0, 1'b0, 48'h0}
    };

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[i])
      send_char(dir_rows[i].ch, dir_rows[i].attr, dir_rows[i].first, dir_rows[i].last,
                dir_rows[i].lit);
    drain();

    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      calm <= ($urandom_range(5) == 0);
      if (sent >= RANDOM_ITEMS / 2 && sent < RANDOM_ITEMS / 2 + 8) drain();
      if ($urandom_range(9) == 0) begin
        send_char(8'($urandom), 1'($urandom), 1'($urandom), 1'($urandom), 48'h0);
        sent++;
      end else begin
        len = $urandom_range(1, 8);
        attr = 1'($urandom_range(1));
        for (int k = 0; k < len; k++)
          send_char(pick_char(), attr, k == 0, k == len - 1, 48'h0);
        sent += len;
      end
    end

    calm <= 1'b0;
    drain();
    repeat (12) @(posedge clk_i);
    if (mismatches == 0 && escaped_q.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
design/xte_pkg.sv
design/xte_front.sv
design/xte_job_fifo.sv
design/xte_back.sv
design/xml_text_escaper_top.sv
bench/tb_xml_text_escaper_top.sv
